// ----- src/gkfi_pkg.sv -----
// Shared constants, word types and sequencer states for the grouped key table.
package gkfi_pkg;

    localparam int MAX_GROUPS  = 16;
    localparam int MAX_ENTRIES = 32;

    // Index and count widths follow from the table plan.
    localparam int GIDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OPEN_W  = $clog2(MAX_GROUPS + 1);
    localparam int FILL_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W  = GIDX_W + ENTRY_W;
    localparam int SLOTS   = MAX_GROUPS * MAX_ENTRIES;

    // Item modes.
    localparam logic MODE_OPEN = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  group_sel;
        logic [31:0] symbol_ref;
        logic [31:0] object_ref;
        logic [31:0] symbol_number;
        logic signed [63:0] addend;
    } t_in_word;

    typedef struct packed {
        logic       ok;
        logic       created;
        logic [4:0] entry_number;
        logic [3:0] new_group_number;
    } t_out_word;

    // One stored key: all four parts must be equal for a match.
    typedef struct packed {
        logic [31:0] symbol_ref;
        logic [31:0] object_ref;
        logic [31:0] symbol_number;
        logic [63:0] addend;
    } t_key;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INSERT,
        ST_EMIT
    } t_state;

endpackage

// ----- src/gkfi_key_store.sv -----
// Key memory with registered read port and the shared key comparator.
module gkfi_key_store (
    input  logic                  i_clk,
    input  logic [gkfi_pkg::SLOT_W-1:0] i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [gkfi_pkg::SLOT_W-1:0] i_wr_addr,
    input  gkfi_pkg::t_key        i_wr_key,
    input  gkfi_pkg::t_key        i_cmp_key,
    output logic                  o_match
);
    import gkfi_pkg::*;

    t_key r_mem [SLOTS];
    t_key r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key <= r_mem[i_rd_addr];
    end

    // Compare the word read last cycle against the held search key.
    assign o_match = (r_rd_key == i_cmp_key);

endmodule

// ----- src/grouped_key_find_or_insert.sv -----
// Top level of the grouped find-or-insert key table.
//
// The block keeps up to MAX_GROUPS groups of up to MAX_ENTRIES four-part keys
// (symbol reference, object reference, symbol index, 64-bit addend). A mode 0
// word opens the next group and returns its number; a mode 1 word searches
// the named group from entry 0 and returns the first matching entry with
// created=0, or appends the key and returns its entry with created=1. A
// refused word (plan full, group not yet opened, group full without a match)
// returns ok=0 with all other fields zero and changes nothing. One word is in
// flight at a time and o_in_stall stays high until its result has been placed
// in the output register. The single read port of the key memory is walked
// one entry per cycle, its registered read data compared in the cycle after
// by the one shared 160-bit comparator. The result register lets the next word
// be accepted while the previous result still waits on i_out_stall. The key
// memory needs no clearing after reset: only entries below a group's fill
// count are ever read.
module grouped_key_find_or_insert (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  gkfi_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gkfi_pkg::t_out_word  o_out_word
);
    import gkfi_pkg::*;

    // Sequencer state.
    t_state r_state, n_state;

    // Plan state: open group count and fill count per group.
    logic [OPEN_W-1:0] r_groups_open;
    logic [FILL_W-1:0] r_group_fill [MAX_GROUPS];

    // Held word and walk counters.
    t_key              r_key, n_key;
    logic [GIDX_W-1:0] r_gidx, n_gidx;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_rd_e, n_rd_e;
    logic [ENTRY_W-1:0] r_cmp_e, n_cmp_e;
    logic              r_cmp_valid, n_cmp_valid;
    t_out_word         r_res, n_res;

    // Output register.
    logic              r_out_valid;
    t_out_word         r_out_word;

    // Control strobes.
    logic              in_accept;
    logic              out_free;
    logic              open_ok;
    logic              group_ok;
    logic              rd_issue;
    logic              cmp_last;
    logic              group_full;
    logic              match;
    logic              open_we;
    logic              fill_we;
    logic [GIDX_W-1:0] sel_gidx;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign sel_gidx   = GIDX_W'(i_in_word.group_sel);
    assign open_ok    = (r_groups_open != OPEN_W'(MAX_GROUPS));
    assign group_ok   = ({{OPEN_W{1'b0}}, i_in_word.group_sel} <
                         {4'b0, r_groups_open});
    assign rd_issue   = (r_rd_e < r_fill);
    assign cmp_last   = ((FILL_W'(r_cmp_e) + FILL_W'(1)) == r_fill);
    assign group_full = (r_fill == FILL_W'(MAX_ENTRIES));
    assign rd_addr    = {r_gidx, r_rd_e[ENTRY_W-1:0]};
    assign wr_addr    = {r_gidx, r_fill[ENTRY_W-1:0]};

    gkfi_key_store u_key_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr_en   (fill_we),
        .i_wr_addr (wr_addr),
        .i_wr_key  (r_key),
        .i_cmp_key (r_key),
        .o_match   (match)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_word.mode == MODE_OPEN || !group_ok) begin
                        n_state = ST_EMIT;
                    end else if (r_group_fill[sel_gidx] == '0) begin
                        n_state = ST_INSERT;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_cmp_valid && match) begin
                    n_state = ST_EMIT;
                end else if (r_cmp_valid && cmp_last) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and strobes.
    always_comb begin
        n_key       = r_key;
        n_gidx      = r_gidx;
        n_fill      = r_fill;
        n_rd_e      = r_rd_e;
        n_cmp_e     = r_cmp_e;
        n_cmp_valid = 1'b0;
        n_res       = r_res;
        open_we     = 1'b0;
        fill_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_key.symbol_ref    = i_in_word.symbol_ref;
                n_key.object_ref    = i_in_word.object_ref;
                n_key.symbol_number = i_in_word.symbol_number;
                n_key.addend        = i_in_word.addend;
                n_gidx = sel_gidx;
                n_fill = r_group_fill[sel_gidx];
                n_rd_e = '0;
                n_res  = '0;
                if (in_accept && i_in_word.mode == MODE_OPEN && open_ok) begin
                    open_we = 1'b1;
                    n_res.ok = 1'b1;
                    n_res.new_group_number = 4'(r_groups_open);
                end
            end
            ST_SEARCH: begin
                // Issue the next read and compare the previous one.
                n_cmp_valid = rd_issue;
                n_cmp_e     = r_rd_e[ENTRY_W-1:0];
                n_rd_e      = r_rd_e + FILL_W'(rd_issue);
                if (r_cmp_valid && match) begin
                    n_res.ok           = 1'b1;
                    n_res.entry_number = 5'(r_cmp_e);
                end
            end
            ST_INSERT: begin
                if (!group_full) begin
                    fill_we            = 1'b1;
                    n_res.ok           = 1'b1;
                    n_res.created      = 1'b1;
                    n_res.entry_number = 5'(r_fill);
                end
            end
            ST_EMIT: begin
                n_res = r_res;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Sequencer and plan registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_groups_open <= '0;
            r_cmp_valid   <= 1'b0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_group_fill[g] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= n_cmp_valid;
            if (open_we) begin
                r_groups_open <= r_groups_open + OPEN_W'(1);
                r_group_fill[GIDX_W'(r_groups_open)] <= '0;
            end
            if (fill_we) begin
                r_group_fill[r_gidx] <= r_fill + FILL_W'(1);
            end
        end
    end

    // Held word, walk counters and result.
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_gidx  <= n_gidx;
        r_fill  <= n_fill;
        r_rd_e  <= n_rd_e;
        r_cmp_e <= n_cmp_e;
        r_res   <= n_res;
    end

    // Output register: load from the emit step, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_out_word <= r_res;
        end
    end

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_groups_open <= OPEN_W'(MAX_GROUPS))
        else $error("open group count beyond plan");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_we |-> (r_fill < FILL_W'(MAX_ENTRIES)))
        else $error("insert into full group");

    a_cmp_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && r_cmp_valid) |-> (FILL_W'(r_cmp_e) < r_fill))
        else $error("compare beyond group fill");

    a_created_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.created) |-> r_out_word.ok)
        else $error("created without ok");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after accepting a word");

endmodule
